>>> hdl/esf_pkg.sv
package esf_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned SpeedW = CountW + 1;
  localparam int unsigned ByteW  = 8;

  localparam logic [CountW-1:0] SPIKE_LIMIT_RESET = 16'd1000;
  localparam logic [ByteW-1:0]  FRAME_HEAD0       = 8'h80;
  localparam logic [ByteW-1:0]  FRAME_HEAD1       = 8'h90;
  localparam logic [ByteW-1:0]  DIR_POS_A         = 8'h01;
  localparam logic [ByteW-1:0]  DIR_POS_B         = 8'h00;

  typedef logic [CountW-1:0]        count_t;
  typedef logic signed [SpeedW-1:0] speed_t;
  typedef logic [ByteW-1:0]         byte_t;

  typedef struct packed {
    logic   neg_a;
    count_t mag_a;
    logic   neg_b;
    count_t mag_b;
  } frame_rec_t;

  function automatic speed_t speed_abs(speed_t v);
    return v[SpeedW-1] ? speed_t'(-v) : v;
  endfunction

endpackage

>>> hdl/esf_if.sv
interface esf_sample_if
  import esf_pkg::*;
();
  logic   valid;
  logic   ready;
  count_t count_a;
  count_t count_b;

  modport source (output valid, output count_a, output count_b, input ready);
  modport sink   (input valid, input count_a, input count_b, output ready);
endinterface

interface esf_frame_if
  import esf_pkg::*;
();
  logic  valid;
  logic  ready;
  byte_t frame_byte;
  logic  frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink   (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface esf_cfg_if
  import esf_pkg::*;
();
  logic   valid;
  logic   ready;
  count_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hdl/encoder_speed_spike_filter_frame_core.sv
// Encoder speed spike filter with telemetry framing.
// sample (sink): one beat carries count_a and count_b, the raw 16-bit counts
//   of two encoders. Per wheel the speed is new count minus previous count;
//   a speed whose magnitude exceeds spike_limit is replaced by the wheel's
//   previous speed.
// frame (source): eleven beats per sample: 0x80, 0x90, direction A, three
//   magnitude bytes of A, direction B, three magnitude bytes of B, and an
//   8-bit additive checksum, on which frame_last is high.
// cfg (sink): writes spike_limit; always ready. Write only while idle.
// Frame valid follows the sample via the held speeds and the tx busy reg.
// Throughput: one frame byte per cycle while frame is ready, set by the
//   byte serializer; one sample is buffered while a frame is being sent, and
//   with a sample buffered, frames leave back to back without gaps.
// Reset (rst, synchronous): previous counts and held speeds clear to zero,
//   spike_limit returns to 1000, buffered and in-flight frames are dropped.
// A stall on frame holds the current byte; once the buffer is full, sample
//   ready drops until the buffered sample moves into the serializer.
module encoder_speed_spike_filter_frame_core
  import esf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  esf_sample_if.sink   sample,
  esf_cfg_if.sink      cfg,
  esf_frame_if.source  frame
);

  count_t     spike_limit;
  count_t     prev_count_a;
  count_t     prev_count_b;
  speed_t     held_speed_a;
  speed_t     held_speed_b;
  logic       hold_valid;
  logic       accept;
  logic       load_ready;
  speed_t     diff_a;
  speed_t     diff_b;
  speed_t     speed_a_next;
  speed_t     speed_b_next;
  speed_t     abs_a;
  speed_t     abs_b;
  frame_rec_t rec;

  assign cfg.ready    = 1'b1;
  assign sample.ready = !hold_valid;
  assign accept       = sample.valid && sample.ready;

  assign diff_a = speed_t'({1'b0, sample.count_a}) - speed_t'({1'b0, prev_count_a});
  assign diff_b = speed_t'({1'b0, sample.count_b}) - speed_t'({1'b0, prev_count_b});

  assign speed_a_next = (speed_abs(diff_a) > speed_t'({1'b0, spike_limit})) ?
                        held_speed_a : diff_a;
  assign speed_b_next = (speed_abs(diff_b) > speed_t'({1'b0, spike_limit})) ?
                        held_speed_b : diff_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_limit <= SPIKE_LIMIT_RESET;
    end else if (cfg.valid && cfg.ready) begin
      spike_limit <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_count_a <= '0;
      prev_count_b <= '0;
      held_speed_a <= '0;
      held_speed_b <= '0;
      hold_valid   <= 1'b0;
    end else begin
      if (accept) begin
        prev_count_a <= sample.count_a;
        prev_count_b <= sample.count_b;
        held_speed_a <= speed_a_next;
        held_speed_b <= speed_b_next;
        hold_valid   <= 1'b1;
      end else if (load_ready) begin
        hold_valid <= 1'b0;
      end
    end
  end

  // held speeds double as the buffered sample until the serializer takes it
  assign abs_a     = speed_abs(held_speed_a);
  assign abs_b     = speed_abs(held_speed_b);
  assign rec.neg_a = held_speed_a[SpeedW-1];
  assign rec.mag_a = abs_a[CountW-1:0];
  assign rec.neg_b = held_speed_b[SpeedW-1];
  assign rec.mag_b = abs_b[CountW-1:0];

  esf_frame_tx u_tx (
    .clk        (clk),
    .rst        (rst),
    .load_valid (hold_valid),
    .load_ready (load_ready),
    .load_rec   (rec),
    .frame      (frame)
  );

`ifndef ASSERT_OFF
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(prev_count_a) && $stable(held_speed_a) &&
                $stable(prev_count_b) && $stable(held_speed_b))
    else $error("filter state changed without a sample beat");

  a_speed_in_limit: assert property (@(posedge clk) disable iff (rst)
    accept && speed_abs(diff_a) <= speed_t'({1'b0, spike_limit}) |=> held_speed_a == $past(diff_a))
    else $error("in-limit speed A not taken");

  a_buffer_drains: assert property (@(posedge clk) disable iff (rst)
    hold_valid && load_ready |=> !hold_valid)
    else $error("buffered sample not released after load");
`endif

endmodule

>>> hdl/esf_frame_tx.sv
module esf_frame_tx
  import esf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load_valid,
  output logic              load_ready,
  input  frame_rec_t        load_rec,
  esf_frame_if.source       frame
);

  localparam logic [3:0] POS_HEAD0 = 4'd0;
  localparam logic [3:0] POS_HEAD1 = 4'd1;
  localparam logic [3:0] POS_DIR_A = 4'd2;
  localparam logic [3:0] POS_A_HI  = 4'd3;
  localparam logic [3:0] POS_A_MID = 4'd4;
  localparam logic [3:0] POS_A_LO  = 4'd5;
  localparam logic [3:0] POS_DIR_B = 4'd6;
  localparam logic [3:0] POS_B_HI  = 4'd7;
  localparam logic [3:0] POS_B_MID = 4'd8;
  localparam logic [3:0] POS_B_LO  = 4'd9;
  localparam logic [3:0] POS_SUM   = 4'd10;

  logic       busy;
  logic [3:0] idx;
  frame_rec_t rec;
  byte_t      csum;
  byte_t      csum_next;
  byte_t      dir_a_next;
  byte_t      dir_b_next;
  logic       beat;
  logic       load;

  assign beat       = frame.valid && frame.ready;
  assign load_ready = !busy || (beat && idx == POS_SUM);
  assign load       = load_valid && load_ready;

  assign dir_a_next = load_rec.neg_a ? ~DIR_POS_A & 8'h01 : DIR_POS_A;
  assign dir_b_next = load_rec.neg_b ? ~DIR_POS_B & 8'h01 : DIR_POS_B;
  assign csum_next  = FRAME_HEAD0 + FRAME_HEAD1 + dir_a_next + load_rec.mag_a[15:8]
                    + load_rec.mag_a[7:0] + dir_b_next + load_rec.mag_b[15:8]
                    + load_rec.mag_b[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= POS_HEAD0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= POS_HEAD0;
    end else if (beat) begin
      if (idx == POS_SUM) begin
        busy <= 1'b0;
      end
      idx <= idx + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec  <= load_rec;
      csum <= csum_next;
    end
  end

  always_comb begin
    unique case (idx)
      POS_HEAD0: frame.frame_byte = FRAME_HEAD0;
      POS_HEAD1: frame.frame_byte = FRAME_HEAD1;
      POS_DIR_A: frame.frame_byte = rec.neg_a ? ~DIR_POS_A & 8'h01 : DIR_POS_A;
      POS_A_HI:  frame.frame_byte = 8'h00;
      POS_A_MID: frame.frame_byte = rec.mag_a[15:8];
      POS_A_LO:  frame.frame_byte = rec.mag_a[7:0];
      POS_DIR_B: frame.frame_byte = rec.neg_b ? ~DIR_POS_B & 8'h01 : DIR_POS_B;
      POS_B_HI:  frame.frame_byte = 8'h00;
      POS_B_MID: frame.frame_byte = rec.mag_b[15:8];
      POS_B_LO:  frame.frame_byte = rec.mag_b[7:0];
      POS_SUM:   frame.frame_byte = csum;
      default:   frame.frame_byte = 8'h00;
    endcase
  end

  assign frame.valid      = busy;
  assign frame.frame_last = (idx == POS_SUM);

`ifndef ASSERT_OFF
  a_load_head: assert property (@(posedge clk) disable iff (rst)
    load |=> frame.valid && frame.frame_byte == FRAME_HEAD0)
    else $error("frame does not start with header byte");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    beat && frame.frame_last && !load_valid |=> !frame.valid)
    else $error("frame continues past checksum beat");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    busy && idx > POS_SUM |-> 1'b0)
    else $error("byte index ran past frame end");
`endif

endmodule
